// ===== rtl/core/bpfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfb_pkg
// Shared types, widths and helpers of the bmp pixel framebuffer blitter.
// ----------------------------------------------------------------------------
package bpfb_pkg;

    // largest image dimension and derived widths
    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = CNT_W + 1;
    localparam int OFF_W    = 12;
    localparam int ADDR_W   = 27;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    // alpha byte of the 32-bit format
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_LEFT_COL     = 3'd2,
        REG_TOP_ROW      = 3'd3,
        REG_SCREEN_XRES  = 3'd4,
        REG_SCREEN_YRES  = 3'd5,
        REG_OUT_MODE     = 3'd6,
        REG_SRC_BYTES    = 3'd7
    } cfg_index_t;

    // framebuffer formats
    typedef enum logic {
        MODE_RGB565 = 1'b0,
        MODE_BGRA   = 1'b1
    } out_mode_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [OFF_W-1:0] left_col;
        logic [OFF_W-1:0] top_row;
        logic [DIM_W-1:0] screen_xres;
        logic [DIM_W-1:0] screen_yres;
        out_mode_t        out_mode;
        logic [1:0]       src_bytes;
        logic             reject;
    } cfg_t;

    // position of the current item in the image
    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } pos_t;

    // clamp a dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bpfb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfb_cfg
// Configuration registers with dimension clamping and the height bounds check.
// ----------------------------------------------------------------------------
module bpfb_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [bpfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpfb_pkg::CFG_DATA_W-1:0] cfg_data,
    output bpfb_pkg::cfg_t                  cfg
);

    logic [bpfb_pkg::DIM_W-1:0] width_reg;
    logic [bpfb_pkg::DIM_W-1:0] height_reg;
    logic [bpfb_pkg::OFF_W-1:0] left_col_reg;
    logic [bpfb_pkg::OFF_W-1:0] top_row_reg;
    logic [bpfb_pkg::DIM_W-1:0] xres_reg;
    logic [bpfb_pkg::DIM_W-1:0] yres_reg;
    bpfb_pkg::out_mode_t        mode_reg;
    logic [1:0]                 src_bytes_reg;
    logic [bpfb_pkg::DIM_W:0]   bottom_edge;

    // register writes, image dimensions stored already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= bpfb_pkg::DIM_W'(1);
            height_reg    <= bpfb_pkg::DIM_W'(1);
            left_col_reg  <= '0;
            top_row_reg   <= '0;
            xres_reg      <= bpfb_pkg::DIM_W'(1);
            yres_reg      <= bpfb_pkg::DIM_W'(1);
            mode_reg      <= bpfb_pkg::MODE_RGB565;
            src_bytes_reg <= 2'd3;
        end
        else if (cfg_valid)
        begin
            case (bpfb_pkg::cfg_index_t'(cfg_index))
                bpfb_pkg::REG_IMAGE_WIDTH:  width_reg <= bpfb_pkg::clamp_dim(cfg_data);
                bpfb_pkg::REG_IMAGE_HEIGHT: height_reg <= bpfb_pkg::clamp_dim(cfg_data);
                bpfb_pkg::REG_LEFT_COL:     left_col_reg <= cfg_data[bpfb_pkg::OFF_W-1:0];
                bpfb_pkg::REG_TOP_ROW:      top_row_reg <= cfg_data[bpfb_pkg::OFF_W-1:0];
                bpfb_pkg::REG_SCREEN_XRES:  xres_reg <= cfg_data;
                bpfb_pkg::REG_SCREEN_YRES:  yres_reg <= cfg_data;
                bpfb_pkg::REG_OUT_MODE:     mode_reg <= bpfb_pkg::out_mode_t'(cfg_data[0]);
                bpfb_pkg::REG_SRC_BYTES:    src_bytes_reg <= cfg_data[1:0];
                default:                    width_reg <= width_reg;
            endcase
        end
    end

    // image bottom edge against the screen height
    assign bottom_edge = (bpfb_pkg::DIM_W+1)'(height_reg)
                       + (bpfb_pkg::DIM_W+1)'(top_row_reg);

    always_comb
    begin
        cfg.width       = width_reg;
        cfg.height      = height_reg;
        cfg.left_col    = left_col_reg;
        cfg.top_row     = top_row_reg;
        cfg.screen_xres = xres_reg;
        cfg.screen_yres = yres_reg;
        cfg.out_mode    = mode_reg;
        cfg.src_bytes   = src_bytes_reg;
        cfg.reject      = bottom_edge > (bpfb_pkg::DIM_W+1)'(yres_reg);
    end

endmodule

// ===== rtl/core/bpfb_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfb_walker
// Row and column counters that walk the image one item at a time.
// ----------------------------------------------------------------------------
module bpfb_walker (
    input  logic           clk,
    input  logic           rst_n,
    input  bpfb_pkg::cfg_t cfg,
    input  logic           advance,
    output bpfb_pkg::pos_t pos
);

    logic [bpfb_pkg::CNT_W-1:0] row_reg;
    logic [bpfb_pkg::CNT_W-1:0] col_reg;
    logic [bpfb_pkg::CNT_W-1:0] row_next;
    logic [bpfb_pkg::CNT_W-1:0] col_next;
    logic [bpfb_pkg::CNT_W-1:0] row_cur;
    logic [bpfb_pkg::CNT_W-1:0] col_cur;
    logic [bpfb_pkg::DIM_W-1:0] row_inc;
    logic [bpfb_pkg::DIM_W-1:0] col_inc;
    logic                       outside;

    // restart when a register write left the counters outside the image
    assign outside = (bpfb_pkg::DIM_W'(row_reg) >= cfg.height)
                  || (bpfb_pkg::DIM_W'(col_reg) >= cfg.width);
    assign row_cur = outside ? '0 : row_reg;
    assign col_cur = outside ? '0 : col_reg;
    assign row_inc = bpfb_pkg::DIM_W'(row_cur) + bpfb_pkg::DIM_W'(1);
    assign col_inc = bpfb_pkg::DIM_W'(col_cur) + bpfb_pkg::DIM_W'(1);

    // step left to right, then to the next row, wrapping after the last
    always_comb
    begin
        if (col_inc >= cfg.width)
        begin
            col_next = '0;
            row_next = (row_inc >= cfg.height) ? '0 : row_inc[bpfb_pkg::CNT_W-1:0];
        end
        else
        begin
            col_next = col_inc[bpfb_pkg::CNT_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_comb
    begin
        pos.row  = row_cur;
        pos.col  = col_cur;
        pos.last = (row_inc == cfg.height) && (col_inc == cfg.width);
    end

endmodule

// ===== rtl/core/bpfb_format.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfb_format
// Framebuffer address and pixel word of one registered item.
// ----------------------------------------------------------------------------
module bpfb_format (
    input  bpfb_pkg::cfg_t                    cfg,
    input  logic [7:0]                        blue,
    input  logic [7:0]                        green,
    input  logic [7:0]                        red,
    input  logic [bpfb_pkg::DIM_W-1:0]        screen_row,
    input  logic [bpfb_pkg::CNT_W-1:0]        col,
    output logic [bpfb_pkg::ADDR_W-1:0]       address,
    output logic [bpfb_pkg::WORD_W-1:0]       word
);

    localparam int MUL_W = 2 * bpfb_pkg::DIM_W;
    localparam int LIN_W = MUL_W + 1;
    localparam int SCL_W = LIN_W + 2;

    logic [7:0]                 b_m;
    logic [7:0]                 g_m;
    logic [7:0]                 r_m;
    logic [bpfb_pkg::DIM_W-1:0] screen_col;
    logic [MUL_W-1:0]           row_base;
    logic [LIN_W-1:0]           linear;
    logic [SCL_W-1:0]           scaled;

    // zero the bytes beyond the source pixel size
    assign b_m = (cfg.src_bytes < 2'd1) ? 8'd0 : blue;
    assign g_m = (cfg.src_bytes < 2'd2) ? 8'd0 : green;
    assign r_m = (cfg.src_bytes < 2'd3) ? 8'd0 : red;

    // pixel index on screen, then scaled by bytes per pixel
    assign screen_col = bpfb_pkg::DIM_W'(cfg.left_col) + bpfb_pkg::DIM_W'(col);
    assign row_base   = MUL_W'(screen_row) * MUL_W'(cfg.screen_xres);
    assign linear     = LIN_W'(row_base) + LIN_W'(screen_col);
    assign scaled     = (cfg.out_mode == bpfb_pkg::MODE_BGRA)
                      ? {linear, 2'b00} : {1'b0, linear, 1'b0};

    always_comb
    begin
        if (cfg.reject)
        begin
            address = '0;
            word    = '0;
        end
        else
        begin
            address = scaled[bpfb_pkg::ADDR_W-1:0];
            if (cfg.out_mode == bpfb_pkg::MODE_BGRA)
            begin
                word = {bpfb_pkg::ALPHA_BYTE, r_m, g_m, b_m};
            end
            else
            begin
                word = {16'd0, r_m[7:3], g_m[7:2], b_m[7:3]};
            end
        end
    end

endmodule

// ===== rtl/core/bmp_pixel_framebuffer_blitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pixel_framebuffer_blitter
// Streams bottom-up BMP pixels into framebuffer writes (RGB565 or BGRA).
// ----------------------------------------------------------------------------
// an accepted item passes the input register, then the result register
// throughput: 1 item per cycle while out_ready holds, set by the input and result registers
// in_ready stays high while the result register is free or being emptied
// reset: registers return to defaults (1x1 image, 1x1 screen, RGB565,
// 3 source bytes), counters to the first pixel, pipeline empty
module bmp_pixel_framebuffer_blitter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpfb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel_byte0,
    input  logic [7:0]                      pixel_byte1,
    input  logic [7:0]                      pixel_byte2,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bpfb_pkg::ADDR_W-1:0]     fb_address,
    output logic [bpfb_pkg::WORD_W-1:0]     pixel_word,
    output logic                            status,
    output logic                            last_of_image
);

    bpfb_pkg::cfg_t             cfg;
    bpfb_pkg::pos_t             pos;
    logic                       in_take;
    logic                       s1_move;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 s1_b_reg;
    logic [7:0]                 s1_g_reg;
    logic [7:0]                 s1_r_reg;
    logic [bpfb_pkg::DIM_W-1:0] s1_srow_reg;
    logic [bpfb_pkg::CNT_W-1:0] s1_col_reg;
    logic                       s1_last_reg;
    logic [bpfb_pkg::DIM_W-1:0] srow;
    logic [bpfb_pkg::ADDR_W-1:0] addr_calc;
    logic [bpfb_pkg::WORD_W-1:0] word_calc;
    logic [bpfb_pkg::ADDR_W-1:0] addr_reg;
    logic [bpfb_pkg::WORD_W-1:0] word_reg;
    logic                       status_reg;
    logic                       last_reg;

    assign cfg_ready = 1'b1;

    bpfb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpfb_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (in_take),
        .pos     (pos)
    );

    // pipeline handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // screen row of the current image row, bottom row first
    assign srow = cfg.height - bpfb_pkg::DIM_W'(1)
                + bpfb_pkg::DIM_W'(cfg.top_row) - bpfb_pkg::DIM_W'(pos.row);

    // input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_b_reg    <= pixel_byte0;
            s1_g_reg    <= pixel_byte1;
            s1_r_reg    <= pixel_byte2;
            s1_srow_reg <= srow;
            s1_col_reg  <= pos.col;
            s1_last_reg <= pos.last;
        end
    end

    bpfb_format u_format (
        .cfg        (cfg),
        .blue       (s1_b_reg),
        .green      (s1_g_reg),
        .red        (s1_r_reg),
        .screen_row (s1_srow_reg),
        .col        (s1_col_reg),
        .address    (addr_calc),
        .word       (word_calc)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            addr_reg   <= addr_calc;
            word_reg   <= word_calc;
            status_reg <= cfg.reject;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fb_address    = addr_reg;
    assign pixel_word    = word_reg;
    assign status        = status_reg;
    assign last_of_image = last_reg;

endmodule

// ===== tb/tb_bmp_pixel_framebuffer_blitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_framebuffer_blitter
// Streams pixels through the blitter under several register settings and
// idle patterns, predicts the framebuffer address, pixel word, status and
// end-of-image flag of every pixel and compares them with the results.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_framebuffer_blitter;

    // one framebuffer write as the block reports it
    typedef struct packed {
        logic [bpfb_pkg::ADDR_W-1:0] addr;
        logic [bpfb_pkg::WORD_W-1:0] word;
        logic                        status;
        logic                        last;
    } blit_result_t;

    // one full register setting
    typedef struct packed {
        logic [12:0]         width;
        logic [12:0]         height;
        logic [11:0]         xoff;
        logic [11:0]         yoff;
        logic [12:0]         xres;
        logic [12:0]         yres;
        bpfb_pkg::out_mode_t mode;
        logic [1:0]          src;
    } blit_setting_t;

    // predicts the blitter and holds the framebuffer writes still to come
    class blit_scoreboard;
        logic [12:0]         width_reg;
        logic [12:0]         height_reg;
        logic [11:0]         xoff_reg;
        logic [11:0]         yoff_reg;
        logic [12:0]         xres_reg;
        logic [12:0]         yres_reg;
        bpfb_pkg::out_mode_t mode_reg;
        logic [1:0]          src_reg;
        logic [11:0]         row_cnt;
        logic [11:0]         col_cnt;
        blit_result_t        pending[$];
        int                  errors;

        function new();
            width_reg  = 13'd1;
            height_reg = 13'd1;
            xoff_reg   = '0;
            yoff_reg   = '0;
            xres_reg   = 13'd1;
            yres_reg   = 13'd1;
            mode_reg   = bpfb_pkg::MODE_RGB565;
            src_reg    = 2'd3;
            row_cnt    = '0;
            col_cnt    = '0;
            errors     = 0;
        endfunction

        // image dimensions are limited to 1..MAX_DIM
        function int unsigned dim_of(logic [12:0] v);
            if (v == '0)
            begin
                return 1;
            end
            if (v > bpfb_pkg::MAX_DIM)
            begin
                return bpfb_pkg::MAX_DIM;
            end
            return v;
        endfunction

        function void write_reg(bpfb_pkg::cfg_index_t idx, logic [12:0] data);
            case (idx)
                bpfb_pkg::REG_IMAGE_WIDTH:  width_reg  = data;
                bpfb_pkg::REG_IMAGE_HEIGHT: height_reg = data;
                bpfb_pkg::REG_LEFT_COL:     xoff_reg   = data[11:0];
                bpfb_pkg::REG_TOP_ROW:      yoff_reg   = data[11:0];
                bpfb_pkg::REG_SCREEN_XRES:  xres_reg   = data;
                bpfb_pkg::REG_SCREEN_YRES:  yres_reg   = data;
                bpfb_pkg::REG_OUT_MODE:     mode_reg   = bpfb_pkg::out_mode_t'(data[0]);
                bpfb_pkg::REG_SRC_BYTES:    src_reg    = data[1:0];
                default:                    ;
            endcase
        endfunction

        // expected write for an accepted source pixel
        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned     w;
            int unsigned     h;
            longint unsigned bpp;
            longint unsigned srow;
            longint unsigned addr;
            blit_result_t    want;
            w = dim_of(width_reg);
            h = dim_of(height_reg);
            // a position left outside a shrunk image restarts the walk
            if (row_cnt >= h || col_cnt >= w)
            begin
                row_cnt = '0;
                col_cnt = '0;
            end
            // bytes beyond the source pixel size read as zero
            if (src_reg < 2'd1)
            begin
                b = '0;
            end
            if (src_reg < 2'd2)
            begin
                g = '0;
            end
            if (src_reg < 2'd3)
            begin
                r = '0;
            end
            want.status = (h + yoff_reg) > yres_reg;
            want.last   = (row_cnt == h - 1) && (col_cnt == w - 1);
            want.addr   = '0;
            want.word   = '0;
            if (!want.status)
            begin
                bpp  = (mode_reg == bpfb_pkg::MODE_BGRA) ? 4 : 2;
                // bottom-up image: row 0 lands on the lowest screen row
                srow = h - 1 + yoff_reg - row_cnt;
                addr = (xoff_reg + col_cnt) * bpp + srow * xres_reg * bpp;
                want.addr = bpfb_pkg::ADDR_W'(addr);
                if (mode_reg == bpfb_pkg::MODE_BGRA)
                begin
                    want.word = {bpfb_pkg::ALPHA_BYTE, r, g, b};
                end
                else
                begin
                    want.word = {16'h0000, r[7:3], g[7:2], b[7:3]};
                end
            end
            pending.push_back(want);
            // raster walk, wrapping after the last pixel
            if (col_cnt + 1 >= w)
            begin
                col_cnt = '0;
                row_cnt = (row_cnt + 1 >= h) ? '0 : row_cnt + 12'd1;
            end
            else
            begin
                col_cnt = col_cnt + 12'd1;
            end
        endfunction

        function void check_result(logic [bpfb_pkg::ADDR_W-1:0] addr,
                                   logic [bpfb_pkg::WORD_W-1:0] word,
                                   logic status, logic last);
            blit_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: fb_address %0h pixel_word %0h", addr, word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (addr !== want.addr)
            begin
                $error("fb_address: expected %0h, got %0h", want.addr, addr);
                errors++;
            end
            if (word !== want.word)
            begin
                $error("pixel_word: expected %0h, got %0h", want.word, word);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %0b, got %0b", want.status, status);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_image: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [bpfb_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [bpfb_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_ready;
    logic [7:0]                      pixel_byte0   = '0;
    logic [7:0]                      pixel_byte1   = '0;
    logic [7:0]                      pixel_byte2   = '0;
    logic                            out_valid;
    logic                            out_ready     = 1'b0;
    logic [bpfb_pkg::ADDR_W-1:0]     fb_address;
    logic [bpfb_pkg::WORD_W-1:0]     pixel_word;
    logic                            status;
    logic                            last_of_image;

    int             send_idle_pct = 37;
    int             recv_idle_pct = 76;
    blit_scoreboard sb = new();

    bmp_pixel_framebuffer_blitter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_byte0   (pixel_byte0),
        .pixel_byte1   (pixel_byte1),
        .pixel_byte2   (pixel_byte2),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fb_address    (fb_address),
        .pixel_word    (pixel_word),
        .status        (status),
        .last_of_image (last_of_image)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(fb_address, pixel_word, status, last_of_image);
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // offer one pixel; called and returning at a falling edge
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_byte0 <= b;
        pixel_byte1 <= g;
        pixel_byte2 <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_pixel(b, g, r);
        @(negedge clk);
    endtask

    // stop sending and wait until every write has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // one register write; cfg_valid stays high for the caller
    task automatic write_reg(input bpfb_pkg::cfg_index_t idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // write all registers; unused upper data bits of the offset, mode and source-size writes carry noise
    task automatic program_regs(input blit_setting_t s);
        drain_results();
        write_reg(bpfb_pkg::REG_IMAGE_WIDTH,  s.width);
        write_reg(bpfb_pkg::REG_IMAGE_HEIGHT, s.height);
        write_reg(bpfb_pkg::REG_LEFT_COL,     {1'($urandom), s.xoff});
        write_reg(bpfb_pkg::REG_TOP_ROW,      {1'($urandom), s.yoff});
        write_reg(bpfb_pkg::REG_SCREEN_XRES,  s.xres);
        write_reg(bpfb_pkg::REG_SCREEN_YRES,  s.yres);
        write_reg(bpfb_pkg::REG_OUT_MODE,     {12'($urandom), s.mode});
        write_reg(bpfb_pkg::REG_SRC_BYTES,    {11'($urandom), s.src});
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic blit_setting_t make_setting(
        input int w, input int h, input int xo, input int yo,
        input int xr, input int yr, input bpfb_pkg::out_mode_t m, input int src);
        blit_setting_t s;
        s.width  = 13'(w);
        s.height = 13'(h);
        s.xoff   = 12'(xo);
        s.yoff   = 12'(yo);
        s.xres   = 13'(xr);
        s.yres   = 13'(yr);
        s.mode   = m;
        s.src    = 2'(src);
        return s;
    endfunction

    // mostly small images, sometimes zero or oversized dimensions
    function automatic logic [12:0] pick_dim(input int small_max);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            return 13'($urandom_range(small_max, 1));
        end
        else if (sel < 80)
        begin
            return '0;
        end
        else if (sel < 90)
        begin
            return 13'($urandom_range(8191, 4096));
        end
        return 13'($urandom_range(200, 13));
    endfunction

    function automatic blit_setting_t random_setting();
        blit_setting_t s;
        int            h_eff;
        int            sel;
        s.width  = pick_dim(12);
        s.height = pick_dim(8);
        s.xoff   = ($urandom_range(1)) ? 12'($urandom_range(20)) : 12'($urandom);
        s.yoff   = ($urandom_range(1)) ? 12'($urandom_range(20)) : 12'($urandom);
        sel      = $urandom_range(99);
        if (sel < 50)
        begin
            s.xres = 13'($urandom_range(64, 1));
        end
        else if (sel < 90)
        begin
            s.xres = 13'($urandom);
        end
        else
        begin
            s.xres = (sel < 95) ? 13'd0 : 13'd8191;
        end
        h_eff = sb.dim_of(s.height);
        sel   = $urandom_range(99);
        if (sel < 75)
        begin
            s.yres = 13'(h_eff + s.yoff + $urandom_range(3));
        end
        else if (sel < 90)
        begin
            // out of screen height
            s.yres = 13'(h_eff + s.yoff - 1);
        end
        else
        begin
            s.yres = 13'($urandom);
        end
        s.mode = bpfb_pkg::out_mode_t'($urandom_range(1));
        s.src  = 2'($urandom_range(3));
        return s;
    endfunction

    // random settings and pixels under the current idle pattern
    task automatic run_random(input int total);
        int sent;
        int n;
        int phase_no;
        sent     = 0;
        phase_no = 0;
        while (sent < total)
        begin
            n = $urandom_range(80, 20);
            program_regs(random_setting());
            for (int k = 0; k < n; k++)
            begin
                // sender waits for the block to empty now and then
                if (k == n / 2 && phase_no % 2 == 0)
                begin
                    drain_results();
                end
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            end
            sent     += n;
            phase_no += 1;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 4x2 image offset on a 10-wide screen, one wrap past the end
        program_regs(make_setting(4, 2, 3, 1, 10, 3, bpfb_pkg::MODE_RGB565, 3));
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hF8);
        send_pixel(8'h07, 8'h03, 8'h07);
        send_pixel(8'h80, 8'h40, 8'h20);
        send_pixel(8'h12, 8'h34, 8'h56);

        // source pixel sizes 0, 1 and 2, the first two in the 32-bit format
        program_regs(make_setting(4, 2, 3, 1, 10, 3, bpfb_pkg::MODE_BGRA, 0));
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        program_regs(make_setting(4, 2, 3, 1, 10, 3, bpfb_pkg::MODE_BGRA, 1));
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        program_regs(make_setting(4, 2, 3, 1, 10, 3, bpfb_pkg::MODE_RGB565, 2));
        send_pixel(8'hFF, 8'hFF, 8'hFF);

        // image reaching below the screen: every pixel rejected
        program_regs(make_setting(4, 4, 1, 2, 10, 5, bpfb_pkg::MODE_BGRA, 3));
        send_pixel(8'h5A, 8'hA5, 8'hC3);
        send_pixel(8'hFF, 8'hFF, 8'hFF);

        // zero dimensions and zero stride
        program_regs(make_setting(0, 0, 4095, 0, 0, 1, bpfb_pkg::MODE_RGB565, 3));
        send_pixel(8'hFF, 8'h00, 8'hFF);

        // oversized dimensions, largest offsets, address wraps
        program_regs(make_setting(8191, 8191, 4095, 4095, 8191, 8191,
                                  bpfb_pkg::MODE_BGRA, 3));
        send_pixel(8'h01, 8'h02, 8'h03);
        send_pixel(8'hFE, 8'hFD, 8'hFC);

        // shrinking the image under the current position restarts the walk
        program_regs(make_setting(3, 2, 0, 0, 3, 2, bpfb_pkg::MODE_RGB565, 3));
        send_pixel(8'h10, 8'h20, 8'h30);
        send_pixel(8'h11, 8'h21, 8'h31);
        send_pixel(8'h12, 8'h22, 8'h32);
        send_pixel(8'h13, 8'h23, 8'h33);
        program_regs(make_setting(3, 1, 0, 0, 3, 2, bpfb_pkg::MODE_RGB565, 3));
        send_pixel(8'h14, 8'h24, 8'h34);

        // random part under three idle patterns
        run_random(430);
        send_idle_pct = 76;
        recv_idle_pct = 37;
        run_random(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(430);

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
